// ===== rtl/per_sender_stale_frame_filter_core_macros.svh =====
// Assertion macros used by the stale frame filter checker.
`ifndef PER_SENDER_STALE_FRAME_FILTER_CORE_MACROS_SVH
`define PER_SENDER_STALE_FRAME_FILTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PSSFF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define PSSFF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pssff_pkg.sv =====
// Types and constants of the per-sender stale frame filter.
`timescale 1ns / 1ps

package pssff_pkg;

    localparam int KEY_LEN_W = 4;
    localparam int CNT_W     = 32;

    typedef enum logic [1:0] {
        OP_RECEIVE = 2'd0,
        OP_REMOVE  = 2'd1,
        OP_QUERY   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        PUB_ACCEPTED     = 2'd0,
        PUB_BACKPRESSURE = 2'd1,
        PUB_FAILED       = 2'd2
    } t_pub;

    typedef enum logic [3:0] {
        ST_ACCEPTED     = 4'd0,
        ST_BAD_SENDER   = 4'd1,
        ST_MALFORMED    = 4'd2,
        ST_STALE        = 4'd3,
        ST_BACKPRESSURE = 4'd4,
        ST_FAILED       = 4'd5,
        ST_REMOVED      = 4'd6,
        ST_NOT_FOUND    = 4'd7,
        ST_FOUND        = 4'd8
    } t_status;

    typedef struct packed {
        logic [1:0]           op;
        logic [63:0]          sender_key;
        logic [KEY_LEN_W-1:0] key_length;
        logic                 decode_ok;
        logic [7:0]           decode_error_code;
        logic [31:0]          frame_sequence;
        logic [31:0]          frame_time_us;
        logic                 needs_convert;
        logic                 convert_ok;
        logic [1:0]           publish_outcome;
    } t_req;

    typedef struct packed {
        logic [CNT_W-1:0] accepted;
        logic [CNT_W-1:0] dropped;
        logic [CNT_W-1:0] rejected;
        logic [CNT_W-1:0] failed;
        logic             seq_valid;
        logic [31:0]      last_seq;
        logic [31:0]      last_time;
    } t_stats;

    typedef struct packed {
        t_status    status;
        logic [7:0] decode_error_out;
        t_stats     stats;
    } t_rsp;

endpackage

// ===== rtl/pssff_if.sv =====
// Request and response channel interfaces of the stale frame filter.
`timescale 1ns / 1ps

interface pssff_req_if
    import pssff_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [1:0]           op;
    logic [63:0]          sender_key;
    logic [KEY_LEN_W-1:0] key_length;
    logic                 decode_ok;
    logic [7:0]           decode_error_code;
    logic [31:0]          frame_sequence;
    logic [31:0]          frame_time_us;
    logic                 needs_convert;
    logic                 convert_ok;
    logic [1:0]           publish_outcome;

    modport source (
        output valid, op, sender_key, key_length, decode_ok, decode_error_code,
               frame_sequence, frame_time_us, needs_convert, convert_ok,
               publish_outcome,
        input  ready
    );

    modport sink (
        input  valid, op, sender_key, key_length, decode_ok, decode_error_code,
               frame_sequence, frame_time_us, needs_convert, convert_ok,
               publish_outcome,
        output ready
    );
endinterface

interface pssff_rsp_if
    import pssff_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [3:0]       status;
    logic [7:0]       decode_error_out;
    logic [CNT_W-1:0] accepted_count;
    logic [CNT_W-1:0] dropped_count;
    logic [CNT_W-1:0] rejected_count;
    logic [CNT_W-1:0] failed_count;
    logic             has_last;
    logic [31:0]      last_seq_out;
    logic [31:0]      last_time_out;

    modport source (
        output valid, status, decode_error_out, accepted_count, dropped_count,
               rejected_count, failed_count, has_last, last_seq_out, last_time_out,
        input  ready
    );

    modport sink (
        input  valid, status, decode_error_out, accepted_count, dropped_count,
               rejected_count, failed_count, has_last, last_seq_out, last_time_out,
        output ready
    );
endinterface

// ===== rtl/pssff_match.sv =====
// Parallel key match and lowest-free-slot search over the sender table.
`timescale 1ns / 1ps

module pssff_match
    import pssff_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int KEY_BYTES = 8,
    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int KW = 8 * KEY_BYTES
) (
    input  logic [SLOTS-1:0]     i_used,
    input  logic [KW-1:0]        i_keys [SLOTS],
    input  logic [KEY_LEN_W-1:0] i_lens [SLOTS],
    input  logic [KW-1:0]        i_key,
    input  logic [KEY_LEN_W-1:0] i_len,
    output logic                 o_hit,
    output logic [SW-1:0]        o_hit_idx,
    output logic                 o_free,
    output logic [SW-1:0]        o_free_idx
);

    // Descending scan so the lowest index wins.
    always_comb begin
        o_hit      = 1'b0;
        o_hit_idx  = '0;
        o_free     = 1'b0;
        o_free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (i_used[i] && i_lens[i] == i_len && i_keys[i] == i_key) begin
                o_hit     = 1'b1;
                o_hit_idx = SW'(i);
            end
            if (!i_used[i]) begin
                o_free     = 1'b1;
                o_free_idx = SW'(i);
            end
        end
    end

endmodule

// ===== rtl/per_sender_stale_frame_filter_core.sv =====
// Per-sender stale frame filter: sender table, sequence check and statistics.
//
// Usage:
//   i_req carries one request per handshake: receive a frame, remove a sender
//   or query a sender's statistics. o_rsp returns exactly one response per
//   request, in order, with the status and the matched slot's statistics.
//   A request is taken into an input register, then classified against the
//   sender table by combinational logic that also writes the table and
//   loads the response register.
// Path: an accepted request waits in the input register until the response
//   register is free; its response is then held in the response register.
// Throughput: one request per cycle while o_rsp takes responses. All SLOTS
//   keys are compared at once, and the table update lands in the same cycle,
//   so the next request always sees the updated table.
// Stall: while o_rsp is held off, the response register holds; one more
//   request can wait in the input register, after which i_req.ready drops.
// Reset: i_rst_n low (synchronous) empties both registers and frees every
//   slot; slot contents are rewritten when a slot is allocated.
`timescale 1ns / 1ps

module per_sender_stale_frame_filter_core
    import pssff_pkg::*;
#(
    parameter int SLOTS     = 8,
    parameter int KEY_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pssff_req_if.sink   i_req,
    pssff_rsp_if.source o_rsp
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int KW = 8 * KEY_BYTES;
    localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(KEY_BYTES);

    // Pipeline control
    logic   r_req_valid;
    t_req   r_req;
    logic   r_rsp_valid;
    t_rsp   r_rsp;
    logic   advance;
    logic   fire;

    // Sender table
    logic [SLOTS-1:0]     r_used;
    logic [KW-1:0]        r_keys  [SLOTS];
    logic [KEY_LEN_W-1:0] r_lens  [SLOTS];
    t_stats               r_stats [SLOTS];

    // Classification
    logic          len_ok;
    logic [KW-1:0] key_m;
    logic          hit;
    logic [SW-1:0] hit_idx;
    logic          free;
    logic [SW-1:0] free_idx;
    logic [SW-1:0] sel;
    t_stats        base;
    t_rsp          n_rsp;
    logic          wr_en;
    logic          clr_en;

    // Response register frees up when empty or being taken this cycle.
    assign advance     = !r_rsp_valid || o_rsp.ready;
    assign fire        = r_req_valid && advance;
    assign i_req.ready = !r_req_valid || advance;

    // Bytes at or above the key length never take part in a match.
    always_comb begin
        key_m = '0;
        for (int b = 0; b < KEY_BYTES; b++) begin
            if (KEY_LEN_W'(b) < r_req.key_length) begin
                key_m[8*b +: 8] = r_req.sender_key[8*b +: 8];
            end
        end
    end

    assign len_ok = (r_req.key_length != '0) && (r_req.key_length <= MAX_LEN);

    pssff_match #(
        .SLOTS     (SLOTS),
        .KEY_BYTES (KEY_BYTES)
    ) u_match (
        .i_used     (r_used),
        .i_keys     (r_keys),
        .i_lens     (r_lens),
        .i_key      (key_m),
        .i_len      (r_req.key_length),
        .o_hit      (hit),
        .o_hit_idx  (hit_idx),
        .o_free     (free),
        .o_free_idx (free_idx)
    );

    // Existing slot first, else the lowest free one (fresh, all counters zero).
    assign sel  = hit ? hit_idx : free_idx;
    assign base = hit ? r_stats[sel] : '0;

    always_comb begin
        n_rsp  = '0;
        n_rsp.status = ST_NOT_FOUND;
        wr_en  = 1'b0;
        clr_en = 1'b0;
        unique case (t_op'(r_req.op))
            OP_RECEIVE: begin
                if (!len_ok || (!hit && !free)) begin
                    n_rsp.status = ST_BAD_SENDER;
                end else begin
                    wr_en       = 1'b1;
                    n_rsp.stats = base;
                    if (!r_req.decode_ok) begin
                        n_rsp.stats.rejected   = base.rejected + 1'b1;
                        n_rsp.status           = ST_MALFORMED;
                        n_rsp.decode_error_out = r_req.decode_error_code;
                    end else if (base.seq_valid && r_req.frame_sequence <= base.last_seq) begin
                        n_rsp.stats.dropped = base.dropped + 1'b1;
                        n_rsp.status        = ST_STALE;
                    end else begin
                        // Fresh frame: sequence and time are recorded whatever
                        // the conversion or publish outcome.
                        n_rsp.stats.seq_valid = 1'b1;
                        n_rsp.stats.last_seq  = r_req.frame_sequence;
                        n_rsp.stats.last_time = r_req.frame_time_us;
                        if (r_req.needs_convert && !r_req.convert_ok) begin
                            n_rsp.stats.failed = base.failed + 1'b1;
                            n_rsp.status       = ST_FAILED;
                        end else begin
                            case (t_pub'(r_req.publish_outcome))
                                PUB_ACCEPTED: begin
                                    n_rsp.stats.accepted = base.accepted + 1'b1;
                                    n_rsp.status         = ST_ACCEPTED;
                                end
                                PUB_BACKPRESSURE: begin
                                    n_rsp.stats.dropped = base.dropped + 1'b1;
                                    n_rsp.status        = ST_BACKPRESSURE;
                                end
                                default: begin
                                    n_rsp.stats.failed = base.failed + 1'b1;
                                    n_rsp.status       = ST_FAILED;
                                end
                            endcase
                        end
                    end
                end
            end
            OP_REMOVE: begin
                if (len_ok && hit) begin
                    n_rsp.status = ST_REMOVED;
                    n_rsp.stats  = base;
                    clr_en       = 1'b1;
                end
            end
            OP_QUERY: begin
                if (len_ok && hit) begin
                    n_rsp.status = ST_FOUND;
                    n_rsp.stats  = base;
                end
            end
            default: begin
                n_rsp.status = ST_NOT_FOUND;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_rsp_valid <= 1'b0;
            r_used      <= '0;
        end else begin
            if (i_req.valid && i_req.ready) begin
                r_req_valid <= 1'b1;
            end else if (advance) begin
                r_req_valid <= 1'b0;
            end

            if (fire) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end

            if (fire && wr_en) begin
                r_used[sel] <= 1'b1;
            end else if (fire && clr_en) begin
                r_used[sel] <= 1'b0;
            end
        end
    end

    // Payload registers and slot contents
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_req.op                <= i_req.op;
            r_req.sender_key        <= i_req.sender_key;
            r_req.key_length        <= i_req.key_length;
            r_req.decode_ok         <= i_req.decode_ok;
            r_req.decode_error_code <= i_req.decode_error_code;
            r_req.frame_sequence    <= i_req.frame_sequence;
            r_req.frame_time_us     <= i_req.frame_time_us;
            r_req.needs_convert     <= i_req.needs_convert;
            r_req.convert_ok        <= i_req.convert_ok;
            r_req.publish_outcome   <= i_req.publish_outcome;
        end
        if (fire) begin
            r_rsp <= n_rsp;
        end
        if (fire && wr_en) begin
            r_keys[sel]  <= key_m;
            r_lens[sel]  <= r_req.key_length;
            r_stats[sel] <= n_rsp.stats;
        end
    end

    assign o_rsp.valid            = r_rsp_valid;
    assign o_rsp.status           = r_rsp.status;
    assign o_rsp.decode_error_out = r_rsp.decode_error_out;
    assign o_rsp.accepted_count   = r_rsp.stats.accepted;
    assign o_rsp.dropped_count    = r_rsp.stats.dropped;
    assign o_rsp.rejected_count   = r_rsp.stats.rejected;
    assign o_rsp.failed_count     = r_rsp.stats.failed;
    assign o_rsp.has_last         = r_rsp.stats.seq_valid;
    assign o_rsp.last_seq_out     = r_rsp.stats.last_seq;
    assign o_rsp.last_time_out    = r_rsp.stats.last_time;

endmodule

// ===== rtl/pssff_checker.sv =====
// Port-level checker for the stale frame filter, bound to the top level.
`timescale 1ns / 1ps
`include "per_sender_stale_frame_filter_core_macros.svh"

module pssff_checker
    import pssff_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input logic [3:0]       i_status,
    input logic [7:0]       i_decode_error_out,
    input logic [CNT_W-1:0] i_accepted_count,
    input logic [CNT_W-1:0] i_dropped_count,
    input logic [CNT_W-1:0] i_rejected_count,
    input logic [CNT_W-1:0] i_failed_count,
    input logic             i_has_last,
    input logic [31:0]      i_last_seq_out,
    input logic [31:0]      i_last_time_out
);

    `PSSFF_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_status) && $stable(i_accepted_count), "stalled response changed")

    `PSSFF_ASSERT_NOW(a_err_only_malformed, i_clk, i_rst_n, i_rsp_valid && i_status != ST_MALFORMED, i_decode_error_out == 8'd0, "error code on non-malformed response")

    `PSSFF_ASSERT_NOW(a_miss_zero_stats, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_NOT_FOUND || i_status == ST_BAD_SENDER), i_accepted_count == '0 && i_dropped_count == '0 && i_rejected_count == '0 && i_failed_count == '0 && !i_has_last, "miss carries statistics")

    `PSSFF_ASSERT_NOW(a_fresh_records_seq, i_clk, i_rst_n, i_rsp_valid && (i_status == ST_ACCEPTED || i_status == ST_BACKPRESSURE || i_status == ST_STALE), i_has_last, "sequence not recorded")

    `PSSFF_ASSERT_NOW(a_no_seq_zero, i_clk, i_rst_n, i_rsp_valid && !i_has_last, i_last_seq_out == 32'd0 && i_last_time_out == 32'd0, "last sequence without has_last")

endmodule

bind per_sender_stale_frame_filter_core pssff_checker u_pssff_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_status           (o_rsp.status),
    .i_decode_error_out (o_rsp.decode_error_out),
    .i_accepted_count   (o_rsp.accepted_count),
    .i_dropped_count    (o_rsp.dropped_count),
    .i_rejected_count   (o_rsp.rejected_count),
    .i_failed_count     (o_rsp.failed_count),
    .i_has_last         (o_rsp.has_last),
    .i_last_seq_out     (o_rsp.last_seq_out),
    .i_last_time_out    (o_rsp.last_time_out)
);
